### hdl/assert_macros.svh
// assertion macros shared by the led pixel encoder modules
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define LPE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define LPE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/lpe_pkg.sv
// package for the led pixel spi timing encoder: payload types, constants,
// and the nibble-to-line-word encoding function; no dependencies
package lpe_pkg;

    localparam int PixelWidth    = 24;
    localparam int WordWidth     = 16;
    localparam int PadWidth      = 6;
    localparam int WordsPerPixel = 6;
    localparam int QueueDepthDef = 2;

    localparam logic [PadWidth-1:0] PadMax      = 6'd57;
    localparam logic [PadWidth-1:0] ResetWordsRst = 6'd3;
    localparam logic [3:0]          PatOne      = 4'h7;
    localparam logic [3:0]          PatZero     = 4'h1;
    localparam logic [WordWidth-1:0] ZeroWord   = '0;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_COLOR_ORDER = 1'b0,
        CFG_RESET_WORDS = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [PixelWidth-1:0] pixel_color;
        logic                  first_pixel;
        logic                  last_pixel;
    } pixel_in_t;

    typedef struct packed {
        logic [WordWidth-1:0] line_word;
        logic                 last_word;
    } word_out_t;

    // classified item handed from front to back
    typedef struct packed {
        logic [PixelWidth-1:0] seq_bytes;  // bytes in send order, first on top
        logic                  start_word;
        logic [PadWidth-1:0]   pad_cnt;    // already saturated
    } pix_cmd_t;

    // data bit k of the nibble drives word bits 15-4k down to 12-4k
    function automatic logic [WordWidth-1:0] nibble_word(input logic [3:0] nib);
        logic [WordWidth-1:0] w;
        w = '0;
        for (int k = 0; k < 4; k++) begin
            w[(15 - 4 * k) -: 4] = nib[k] ? PatOne : PatZero;
        end
        return w;
    endfunction

endpackage

### hdl/lpe_front.sv
// front end of the led pixel encoder: accepts pixels, reorders the colour
// bytes and saturates the pad count; depends on lpe_pkg
module lpe_front
    import lpe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  pixel_in_t           in_data,
    input  logic                color_order,
    input  logic [PadWidth-1:0] reset_words,
    output logic                push,
    output pix_cmd_t            push_data,
    input  logic                q_full
);

    logic     valid_reg;
    logic     valid_next;
    pix_cmd_t cmd_reg;
    pix_cmd_t cmd_next;
    logic     take;

    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic [PadWidth-1:0] pad_sat;

    assign push     = valid_reg && !q_full;
    assign in_stall = valid_reg && q_full;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        red     = in_data.pixel_color[7:0];
        green   = in_data.pixel_color[15:8];
        blue    = in_data.pixel_color[23:16];
        pad_sat = (reset_words > PadMax) ? PadMax : reset_words;

        cmd_next = cmd_reg;
        if (take)
        begin
            cmd_next.seq_bytes  = color_order ? {red, green, blue} : {green, red, blue};
            cmd_next.start_word = in_data.first_pixel;
            cmd_next.pad_cnt    = in_data.last_pixel ? pad_sat : '0;
        end
        valid_next = take || (valid_reg && !push);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign push_data = cmd_reg;

endmodule

### hdl/lpe_queue.sv
// short command queue between front and back of the led pixel encoder
// depends on lpe_pkg and assert_macros.svh
`include "assert_macros.svh"

module lpe_queue
    import lpe_pkg::*;
#(
    parameter int DEPTH = QueueDepthDef
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  pix_cmd_t push_data,
    output logic     full,
    input  logic     pop,
    output pix_cmd_t pop_data,
    output logic     q_valid
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    pix_cmd_t          mem [DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_next;
    logic [CntW-1:0]   count_reg;
    logic [CntW-1:0]   count_next;

    assign full     = (count_reg == CntW'(DEPTH));
    assign q_valid  = (count_reg != '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    `LPE_ASSERT(a_no_overflow, clk, rst_n, push |-> !full, "push into full queue")
    `LPE_ASSERT(a_count_bound, clk, rst_n, count_reg <= CntW'(DEPTH), "queue count past depth")

endmodule

### hdl/lpe_back.sv
// back end of the led pixel encoder: word sequencer and output register
// depends on lpe_pkg and assert_macros.svh
`include "assert_macros.svh"

module lpe_back
    import lpe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  pix_cmd_t  pop_data,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output word_out_t out_data
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_START,
        PH_DATA,
        PH_PAD
    } phase_t;

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [PixelWidth-1:0] sr_reg;
    logic [PixelWidth-1:0] sr_next;
    logic [2:0]          cnt_reg;
    logic [2:0]          cnt_next;
    logic [PadWidth-1:0] pad_reg;
    logic [PadWidth-1:0] pad_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    word_out_t           out_reg;
    word_out_t           out_next;

    logic                slot_free;
    logic                emit;
    logic                final_word;
    logic                data_end;
    logic [WordWidth-1:0] word;

    assign slot_free = !out_valid_reg || !out_stall;
    assign emit      = (phase_reg != PH_IDLE) && slot_free;
    assign data_end  = (cnt_reg == 3'(WordsPerPixel - 1));

    always_comb
    begin
        unique case (phase_reg)
            PH_DATA:  final_word = data_end && (pad_reg == '0);
            PH_PAD:   final_word = (pad_reg == PadWidth'(1));
            default:  final_word = 1'b0;
        endcase
        word = (phase_reg == PH_DATA) ? nibble_word(sr_reg[PixelWidth-1 -: 4]) : ZeroWord;
    end

    assign pop = q_valid && ((phase_reg == PH_IDLE) || (emit && final_word));

    always_comb
    begin
        phase_next     = phase_reg;
        sr_next        = sr_reg;
        cnt_next       = cnt_reg;
        pad_next       = pad_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;

        if (emit)
        begin
            out_valid_next     = 1'b1;
            out_next.line_word = word;
            out_next.last_word = final_word;
            unique case (phase_reg)
                PH_START:
                begin
                    phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    sr_next  = {sr_reg[PixelWidth-5:0], 4'h0};
                    cnt_next = cnt_reg + 1'b1;
                    if (data_end)
                    begin
                        phase_next = (pad_reg == '0) ? PH_IDLE : PH_PAD;
                    end
                end
                PH_PAD:
                begin
                    pad_next = pad_reg - 1'b1;
                    if (final_word)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        if (pop)
        begin
            phase_next = pop_data.start_word ? PH_START : PH_DATA;
            sr_next    = pop_data.seq_bytes;
            cnt_next   = '0;
            pad_next   = pop_data.pad_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg  <= sr_next;
        cnt_reg <= cnt_next;
        pad_reg <= pad_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `LPE_ASSERT(a_pop_nonempty, clk, rst_n, pop |-> q_valid, "pop from empty queue")
    `LPE_ASSERT(a_pad_live, clk, rst_n, phase_reg == PH_PAD |-> pad_reg != '0, "empty pad phase")

endmodule

### hdl/led_pixel_spi_timing_encoder_top.sv
// top level of the led pixel spi timing encoder: config registers, front,
// command queue and back; depends on lpe_pkg, lpe_front, lpe_queue, lpe_back
//
//  channel   direction  handshake           payload
//  -------   ---------  ------------------  ------------------------------------
//  in        input      in_valid/in_stall   pixel_color, first_pixel, last_pixel
//  out       output     out_valid/out_stall line_word, last_word
//  cfg       input      cfg_we              cfg_index, cfg_data (no read-back)
//
// one output beat per cycle while out_stall is low; a pixel gives six nibble words,
// plus a frame start word for a first pixel and reset_words (max 57) pad words after
// a frame end; the output beat rate of the word sequencer sets the pixel rate
// a new pixel is taken while earlier ones are still being sent: the front
// register and the command queue hold up to QUEUE_DEPTH + 1 pending pixels
// reset clears the pipeline; color_order resets to 0, reset_words to 3
// out_stall holds the output register; the front stalls only when the queue fills
module led_pixel_spi_timing_encoder_top
    import lpe_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDef
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  pixel_in_t           in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output word_out_t           out_data,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [PadWidth-1:0] cfg_data
);

    // configuration registers
    logic                color_order_reg;
    logic                color_order_next;
    logic [PadWidth-1:0] reset_words_reg;
    logic [PadWidth-1:0] reset_words_next;

    // front to queue to back
    logic     push;
    pix_cmd_t push_data;
    logic     q_full;
    logic     pop;
    pix_cmd_t pop_data;
    logic     q_valid;

    always_comb
    begin
        color_order_next = color_order_reg;
        reset_words_next = reset_words_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_COLOR_ORDER: color_order_next = cfg_data[0];
                CFG_RESET_WORDS: reset_words_next = cfg_data;
                default:         color_order_next = color_order_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_order_reg <= 1'b0;
            reset_words_reg <= ResetWordsRst;
        end
        else
        begin
            color_order_reg <= color_order_next;
            reset_words_reg <= reset_words_next;
        end
    end

    // classify pixel: byte order and saturated pad count
    lpe_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .color_order (color_order_reg),
        .reset_words (reset_words_reg),
        .push        (push),
        .push_data   (push_data),
        .q_full      (q_full)
    );

    // decouples front stalls from the word sequencer
    lpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_valid   (q_valid)
    );

    // start word, six nibble words, pad words
    lpe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .pop_data  (pop_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

### tb/tb_led_pixel_spi_timing_encoder_top.sv
// self-checking testbench for led_pixel_spi_timing_encoder_top: drives pixels and
// register writes, predicts every line word and checks the output stream
// depends on lpe_pkg and the encoder rtl
module tb_led_pixel_spi_timing_encoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lpe_pkg::*;

    // cycles without any accepted beat before the run is declared hung
    localparam int HangLimit  = 4000;
    // length of the long output hold-off used to back up the pipeline
    localparam int HoldCycles = 300;

    // expected line words, kept in send order, plus a copy of the registers
    class line_word_tracker;
        word_out_t           pending_words[$];
        logic                color_order;
        logic [PadWidth-1:0] reset_words;
        int                  mismatches;
        int                  words_checked;

        function new();
            color_order   = 1'b0;
            reset_words   = ResetWordsRst;
            mismatches    = 0;
            words_checked = 0;
        endfunction

        function void set_register(cfg_index_t idx, logic [PadWidth-1:0] value);
            if (idx == CFG_COLOR_ORDER)
            begin
                color_order = value[0];
            end
            else
            begin
                reset_words = value;
            end
        endfunction

        // data bit 0 of the nibble lands in the top nibble of the word
        function logic [WordWidth-1:0] encode_nibble(logic [3:0] nib);
            return {nib[0] ? PatOne : PatZero, nib[1] ? PatOne : PatZero,
                    nib[2] ? PatOne : PatZero, nib[3] ? PatOne : PatZero};
        endfunction

        function void push_word(ref word_out_t words[$], input logic [WordWidth-1:0] w);
            word_out_t beat;
            beat.line_word = w;
            beat.last_word = 1'b0;
            words.push_back(beat);
        endfunction

        function void note_pixel(pixel_in_t px);
            word_out_t  words[$];
            logic [7:0] seq [3];
            int         pad;
            int         i;
            if (color_order)
            begin
                seq = '{px.pixel_color[7:0], px.pixel_color[15:8], px.pixel_color[23:16]};
            end
            else
            begin
                seq = '{px.pixel_color[15:8], px.pixel_color[7:0], px.pixel_color[23:16]};
            end
            pad = (reset_words > PadMax) ? int'(PadMax) : int'(reset_words);
            if (px.first_pixel)
            begin
                push_word(words, ZeroWord);
            end
            for (i = 0; i < 3; i++)
            begin
                push_word(words, encode_nibble(seq[i][7:4]));
                push_word(words, encode_nibble(seq[i][3:0]));
            end
            if (px.last_pixel)
            begin
                for (i = 0; i < pad; i++)
                begin
                    push_word(words, ZeroWord);
                end
            end
            words[words.size() - 1].last_word = 1'b1;
            foreach (words[j])
            begin
                pending_words.push_back(words[j]);
            end
        endfunction

        function void check_word(word_out_t got);
            word_out_t want;
            if (pending_words.size() == 0)
            begin
                $error("unexpected beat: line_word %h last_word %b", got.line_word, got.last_word);
                mismatches++;
                return;
            end
            want = pending_words.pop_front();
            words_checked++;
            if (got.line_word !== want.line_word)
            begin
                $error("line_word: expected %h, got %h", want.line_word, got.line_word);
                mismatches++;
            end
            if (got.last_word !== want.last_word)
            begin
                $error("last_word: expected %b, got %b", want.last_word, got.last_word);
                mismatches++;
            end
        endfunction
    endclass

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #4 clk = ~clk;

    // dut ports, all inputs at known values from time zero
    logic                in_valid  = 1'b0;
    logic                in_stall;
    pixel_in_t           in_data   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    word_out_t           out_data;
    logic                cfg_we    = 1'b0;
    logic [0:0]          cfg_index = '0;
    logic [PadWidth-1:0] cfg_data  = '0;

    led_pixel_spi_timing_encoder_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    line_word_tracker tracker;

    // idling knobs, percent of cycles
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    // one-cycle request for the long output hold-off
    logic hold_req      = 1'b0;
    int   hold_left;

    int   pixels_sent  = 0;
    int   frames_sent  = 0;
    int   hung_cycles  = 0;

    // receiver: random stall, or a long hold-off counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_req)
        begin
            out_stall <= 1'b1;
            hold_left <= HoldCycles;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // output monitor: every accepted beat is checked against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            tracker.check_word(out_data);
        end
    end

    // watchdog: counts cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                hung_cycles <= 0;
            end
            else if (hung_cycles >= HangLimit)
            begin
                $display("timeout: no beat for %0d cycles", HangLimit);
                $display("FAILURE");
                $finish;
            end
            else
            begin
                hung_cycles <= hung_cycles + 1;
            end
        end
    end

    // offer one pixel, with an optional random gap first, and hold it until taken
    task automatic send_pixel(logic [PixelWidth-1:0] color, logic first, logic last);
        pixel_in_t px;
        px.pixel_color = color;
        px.first_pixel = first;
        px.last_pixel  = last;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        tracker.note_pixel(px);
        pixels_sent++;
        if (last)
        begin
            frames_sent++;
        end
    endtask

    // wait until every predicted word has come out, then idle with in_valid low
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tracker.pending_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    // register write, only issued once the block has gone idle
    task automatic write_reg(cfg_index_t idx, logic [PadWidth-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_register(idx, value);
        @(posedge clk);
    endtask

    // mostly well-formed frames of random length, with some stray pixels mixed in
    task automatic send_frames(int count);
        int sent;
        int len;
        int i;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_pixel(PixelWidth'($urandom_range(0, 24'hFFFFFF)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                sent++;
            end
            else
            begin
                len = $urandom_range(1, 6);
                for (i = 0; i < len; i++)
                begin
                    send_pixel(PixelWidth'($urandom_range(0, 24'hFFFFFF)), i == 0,
                               i == len - 1);
                end
                sent += len;
            end
        end
    endtask

    initial
    begin
        tracker = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset register values (green first, three reset words)
        send_pixel(24'h000000, 1'b1, 1'b0);
        send_pixel(24'hFFFFFF, 1'b0, 1'b0);
        send_pixel(24'h0F0F0F, 1'b0, 1'b0);
        send_pixel(24'hF0F0F0, 1'b0, 1'b1);
        // start and end of frame on the same pixel
        send_pixel(24'h123456, 1'b1, 1'b1);

        // red first, no reset words: last pixel word ends the item
        write_reg(CFG_COLOR_ORDER, 6'd1);
        write_reg(CFG_RESET_WORDS, 6'd0);
        send_pixel(24'hA5C3E1, 1'b1, 1'b1);
        send_pixel(24'h00FF00, 1'b0, 1'b1);
        send_pixel(24'h0000FF, 1'b1, 1'b0);

        // largest legal reset count
        write_reg(CFG_RESET_WORDS, PadMax);
        send_pixel(24'hFFFFFF, 1'b1, 1'b1);
        send_pixel(24'h01_02_04, 1'b0, 1'b1);

        // count above range saturates
        write_reg(CFG_RESET_WORDS, 6'd63);
        send_pixel(24'h5A5A5A, 1'b0, 1'b1);
        write_reg(CFG_COLOR_ORDER, 6'd0);
        send_pixel(24'h8142C3, 1'b1, 1'b1);

        write_reg(CFG_RESET_WORDS, 6'd1);
        send_pixel(24'hFF0000, 1'b1, 1'b0);
        send_pixel(24'h0000FF, 1'b0, 1'b1);

        // phase: no idling, with a long output hold-off to fill the pipeline
        write_reg(CFG_COLOR_ORDER, 6'd0);
        write_reg(CFG_RESET_WORDS, 6'($urandom_range(0, 7)));
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        send_frames(60);

        // phase: sender mostly idle
        write_reg(CFG_COLOR_ORDER, 6'd1);
        write_reg(CFG_RESET_WORDS, PadMax);
        send_idle_pct = 69;
        stall_pct     = 0;
        send_frames(60);

        // phase: receiver mostly stalled, with a full pause halfway
        write_reg(CFG_COLOR_ORDER, 6'($urandom_range(0, 1)));
        write_reg(CFG_RESET_WORDS, 6'd63);
        send_idle_pct = 0;
        stall_pct     = 69;
        send_frames(30);
        wait_drained();
        send_frames(30);

        // phase: light idling on both sides
        write_reg(CFG_COLOR_ORDER, 6'd1);
        write_reg(CFG_RESET_WORDS, 6'($urandom_range(0, 63)));
        send_idle_pct = 10;
        stall_pct     = 10;
        send_frames(60);

        // drain and watch for stray beats
        wait_drained();
        stall_pct = 0;
        repeat (100) @(posedge clk);

        $display("sent %0d pixels in %0d frames, checked %0d line words", pixels_sent,
                 frames_sent, tracker.words_checked);
        $display("both color orders, reset counts from zero to above range, four idling mixes");
        if (tracker.mismatches == 0 && tracker.pending_words.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/lpe_pkg.sv
hdl/lpe_front.sv
hdl/lpe_queue.sv
hdl/lpe_back.sv
hdl/led_pixel_spi_timing_encoder_top.sv
tb/tb_led_pixel_spi_timing_encoder_top.sv
